// File: rtl/core/preemptive_priority_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the preemptive priority scheduler
// Clocked, reset-qualified property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define PPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define PPS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Word types, operation codes and time limits of the priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [15:0] TIME_MAX = 16'hFFFF;

  typedef struct packed {
    logic        operation;
    logic [2:0]  slot;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } in_t;

  typedef struct packed {
    logic        busy_res;
    logic [2:0]  running_slot;
    logic        first_run;
    logic        completed;
    logic [15:0] finish_time;
    logic        switched;
    logic [15:0] tick_time;
  } out_t;

  // One task table entry as kept in the table memory.
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } entry_t;

endpackage

// File: rtl/core/pps_table.sv
// ----------------------------------------------------------------------------
// pps_table
// Task table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pps_table #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 40
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler over a memory-held task table.
// ----------------------------------------------------------------------------
//
//   channel | dir | word  | handshake
//   --------+-----+-------+---------------------------
//   in      | in  | in_t  | in_valid_i / in_ready_o
//   out     | out | out_t | out_valid_o / out_ready_i
//
// A load word is written to the table on acceptance and returns no result.
// A tick word holds the input off after acceptance while the
// table memory is swept one entry per cycle through its single read port,
// then the chosen entry is written back.
// Reset clears the flags, the time counter and the last-slot marker; the
// table memory itself is not cleared, since an entry's data is used only once loaded.
// A stalled result sits in the output register; the next word is still taken,
// and a tick only holds in its finish state until that register is free.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

`include "preemptive_priority_scheduler_macros.svh"

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] NO_SLOT   = CNT_W'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Per-slot status flags, all cleared by reset.
  logic [SLOTS-1:0] loaded_q, arrived_q, started_q, done_q;

  logic [15:0]       time_q;
  logic [CNT_W-1:0]  last_q;     // last slot that ran, NO_SLOT when none
  logic [CNT_W-1:0]  cnt_q;      // sweep read address
  logic              rd_vld_q;   // read data belongs to a sweep
  logic [SLOT_W-1:0] rd_slot_q;  // slot whose data is on the read port

  // Best candidate found so far in the sweep.
  logic              have_q;
  logic [SLOT_W-1:0] best_q;
  entry_t            best_entry_q;

  logic   out_valid_q;
  out_t   out_q;
  out_t   out_d;

  // Table memory port signals.
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  entry_t            rd_data;

  logic in_acc, load_acc, tick_acc, load_ok, fin_go, take;
  logic arr_now;
  logic [15:0] rem_dec;
  logic        completed_c;
  logic [15:0] time_inc;

  pps_table #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(entry_t))
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_q[SLOT_W-1:0]),
    .rd_data_o (rd_data)
  );

  // --------------------------------------------------------------------------
  // Handshake and control
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_acc   = in_acc && (in_i.operation == OP_LOAD);
  assign tick_acc   = in_acc && (in_i.operation == OP_TICK);
  // Drop loads that address a slot beyond the table.
  assign load_ok    = int'(in_i.slot) < SLOTS;

  // Finish a tick only when the output register can take the result.
  assign fin_go = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  // Issue one read per sweep cycle until every slot has been addressed.
  assign rd_en = (state_q == S_SCAN) && (cnt_q < CNT_END);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (tick_acc) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // The last read data is consumed in the cycle the counter hits the end.
        if (cnt_q == CNT_END) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sweep evaluation: arrival check and priority compare for one slot
  // --------------------------------------------------------------------------
  assign arr_now = arrived_q[rd_slot_q] ||
                   (loaded_q[rd_slot_q] && (rd_data.arrival <= time_q));
  // Strictly greater keeps the lowest index on equal priority.
  assign take = rd_vld_q && arr_now && !done_q[rd_slot_q] &&
                (!have_q || (rd_data.prio > best_entry_q.prio));

  // --------------------------------------------------------------------------
  // Service the chosen slot
  // --------------------------------------------------------------------------
  assign rem_dec     = best_entry_q.remaining - 16'd1;
  assign completed_c = (rem_dec == 16'd0);
  assign time_inc    = (time_q == TIME_MAX) ? TIME_MAX : (time_q + 16'd1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_q;
    wr_data = best_entry_q;
    if (load_acc && load_ok) begin
      wr_en   = 1'b1;
      wr_addr = SLOT_W'(in_i.slot);
      wr_data = '{arrival: in_i.arrival, remaining: in_i.burst, prio: in_i.prio};
    end else if (fin_go && have_q) begin
      wr_en             = 1'b1;
      wr_data.remaining = rem_dec;
    end
  end

  // Build the report word; an idle tick carries only the time.
  always_comb begin
    out_d           = '0;
    out_d.tick_time = time_q;
    if (have_q) begin
      out_d.busy_res     = 1'b1;
      out_d.running_slot = 3'(best_q);
      out_d.first_run    = !started_q[best_q];
      out_d.completed    = completed_c;
      out_d.finish_time  = completed_c ? time_inc : 16'd0;
      out_d.switched     = (CNT_W'(best_q) != last_q);
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      loaded_q    <= '0;
      arrived_q   <= '0;
      started_q   <= '0;
      done_q      <= '0;
      time_q      <= '0;
      last_q      <= NO_SLOT;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;

      if (load_acc && load_ok) begin
        // Restart the task from scratch; a zero burst is done at once.
        loaded_q[SLOT_W'(in_i.slot)]  <= 1'b1;
        arrived_q[SLOT_W'(in_i.slot)] <= 1'b0;
        started_q[SLOT_W'(in_i.slot)] <= 1'b0;
        done_q[SLOT_W'(in_i.slot)]    <= (in_i.burst == 16'd0);
      end

      if (tick_acc) begin
        cnt_q  <= '0;
        have_q <= 1'b0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end

      if (rd_vld_q && arr_now) begin
        arrived_q[rd_slot_q] <= 1'b1;
      end
      if (take) begin
        have_q <= 1'b1;
      end

      if (fin_go) begin
        time_q <= time_inc;
        if (have_q) begin
          started_q[best_q] <= 1'b1;
          last_q            <= CNT_W'(best_q);
          if (completed_c) begin
            done_q[best_q] <= 1'b1;
          end
        end
      end

      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_slot_q <= cnt_q[SLOT_W-1:0];
    end
    if (take) begin
      best_q       <= rd_slot_q;
      best_entry_q <= rd_data;
    end
    if (fin_go) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PPS_ASSERT(a_done_after_complete, clk_i, rst_ni, fin_go && have_q && completed_c |=> done_q[best_q], "completed slot not marked done")
  `PPS_ASSERT(a_tick_time, clk_i, rst_ni, fin_go |=> out_q.tick_time == $past(time_q), "result time does not match counter")
  `PPS_ASSERT_NEVER(a_arrived_unloaded, clk_i, rst_ni, (arrived_q & ~loaded_q) != '0, "slot arrived without being loaded")
  `PPS_ASSERT_NEVER(a_sweep_bound, clk_i, rst_ni, cnt_q > CNT_END, "sweep address ran past the table")

endmodule
